// ----- sv/fxsin_pkg.sv -----
// Shared constants and types for the Q12 fixed-point sine unit.
// No dependencies; imported by fixed_point_sine_q12_unit.
package fxsin_pkg;

    localparam int ANGLE_W = 21;
    localparam int SINE_W  = 14;
    localparam int CODE_W  = 15;
    localparam int X_W     = 14;
    localparam int Y_W     = 19;

    typedef enum logic [1:0] {
        UNIT_RAW = 2'd0,
        UNIT_DEG = 2'd1,
        UNIT_RAD = 2'd2
    } t_angle_unit;

    // Reciprocal for the degree path: exact floor(a / 45) as (a * RECIP_DEG) >> 27.
    localparam logic [21:0] RECIP_DEG = 22'd2982617;
    localparam int          SHIFT_DEG = 27;
    // Reciprocal for the radian path: (a * 4096) / 3217, off by at most one low.
    localparam logic [21:0] RECIP_RAD = 22'd2670169;
    localparam int          SHIFT_RAD = 21;
    localparam logic [12:0] DIV_RAD   = 13'd3217;

    localparam logic [31:0] K_A = 32'd3370945099;
    localparam logic [31:0] K_B = 32'd2746362156;
    localparam logic [18:0] K_C = 19'd292421;

endpackage

// ----- sv/fixed_point_sine_q12_unit.sv -----
// Top level of the Q12 fixed-point sine unit: angle conversion, quadrant
// fold and a pipelined fifth-order polynomial.
// Depends on fxsin_pkg.
//
// Usage: angles enter on the s_axis channel and one Q12 sine word leaves on
// the m_axis channel for each of them, in order. The angle_unit register is
// written through i_cfg_we and i_cfg_wdata while the unit is idle; it picks
// whether an angle is a raw 15-bit turn, Q12 degrees or Q12 radians.
// The datapath is seven register stages: a reciprocal multiply, a remainder
// correction, the fold with the first polynomial product, and one multiplier
// stage for each further product. One word is taken every cycle while the
// receiver is ready. When the receiver stalls, a full stage holds while its
// successor holds and empty stages still fill, so the pipeline compacts
// before s_axis_tready drops. Reset clears the valid bits and sets the unit
// to raw turns.
module fixed_point_sine_q12_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // [20:0] angle
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata    // [13:0] sine
);
    import fxsin_pkg::*;

    localparam int NSTG = 7;

    t_angle_unit          r_unit;
    logic [NSTG-1:0]      r_vld;
    logic [NSTG:0]        n_en;

    logic [ANGLE_W-1:0]   r1_angle;
    t_angle_unit          r1_unit;
    logic [42:0]          r1_prod;
    logic [42:0]          n1_prod;

    logic [CODE_W-1:0]    r2_code;
    logic [CODE_W-1:0]    n2_code;
    logic [CODE_W-1:0]    n2_qrad;
    logic [12:0]          n2_rem;
    logic [25:0]          n2_back;

    logic [X_W-1:0]       n3_x;
    logic [32:0]          n3_p;
    logic [X_W-1:0]       r3_x;
    logic                 r3_neg;
    logic [Y_W-1:0]       r3_y;

    logic [32:0]          n4_p;
    logic [31:0]          n4_y;
    logic [X_W-1:0]       r4_x;
    logic                 r4_neg;
    logic [Y_W-1:0]       r4_y;

    logic [32:0]          n5_p;
    logic [X_W-1:0]       r5_x;
    logic                 r5_neg;
    logic [Y_W-1:0]       r5_y;

    logic [32:0]          n6_p;
    logic [31:0]          n6_y;
    logic [X_W-1:0]       r6_x;
    logic                 r6_neg;
    logic [Y_W-1:0]       r6_y;

    logic [32:0]          n7_p;
    logic [32:0]          n7_rnd;
    logic [SINE_W-1:0]    n7_mag;
    logic [SINE_W-1:0]    r7_sine;

    always_comb begin
        n_en[NSTG] = m_axis_tready;
        for (int k = NSTG - 1; k >= 0; k--) begin
            n_en[k] = !r_vld[k] || n_en[k+1];
        end
    end

    assign s_axis_tready = n_en[0];
    assign m_axis_tvalid = r_vld[NSTG-1];
    assign m_axis_tdata  = {2'b00, r7_sine};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_unit <= UNIT_RAW;
            r_vld  <= '0;
        end else begin
            if (i_cfg_we) begin
                r_unit <= t_angle_unit'(i_cfg_wdata);
            end
            if (n_en[0]) begin
                r_vld[0] <= s_axis_tvalid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (n_en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // Stage 1: reciprocal multiply for the degree or radian conversion.
    always_comb begin
        if (r_unit == UNIT_RAD) begin
            n1_prod = 43'(s_axis_tdata[ANGLE_W-1:0]) * 43'(RECIP_RAD);
        end else begin
            n1_prod = 43'(s_axis_tdata[ANGLE_W-1:0]) * 43'(RECIP_DEG);
        end
    end

    // Stage 2: the radian quotient may be one low; the remainder modulo 8192
    // is exact because the true remainder stays below twice the divisor.
    always_comb begin
        n2_qrad = r1_prod[SHIFT_RAD+CODE_W-1:SHIFT_RAD];
        n2_back = 26'(n2_qrad[12:0]) * 26'(DIV_RAD);
        n2_rem  = {r1_angle[0], 12'd0} - n2_back[12:0];
        case (r1_unit)
            UNIT_DEG: n2_code = r1_prod[SHIFT_DEG+CODE_W-1:SHIFT_DEG];
            UNIT_RAD: n2_code = n2_qrad + CODE_W'(n2_rem >= DIV_RAD);
            default:  n2_code = r1_angle[CODE_W-1:0];
        endcase
    end

    // Stage 3: fold into the first quadrant and take the first product.
    always_comb begin
        if (r2_code[13]) begin
            n3_x = X_W'(15'd16384 - {1'b0, r2_code[13:0]});
        end else begin
            n3_x = {1'b0, r2_code[12:0]};
        end
        n3_p = 33'(n3_x) * 33'(K_C);
    end

    always_comb begin
        n4_p = 33'(r3_x) * 33'(r3_y);
        n4_y = K_B - {3'd0, n4_p[31:3]};
        n5_p = 33'(r4_x) * 33'(r4_y);
        n6_p = 33'(r5_x) * 33'(r5_y);
        n6_y = K_A - {1'b0, n6_p[31:1]};
        n7_p = 33'(r6_x) * 33'(r6_y);
        n7_rnd = n7_p + 33'd262144;
        n7_mag = n7_rnd[32:19];
    end

    always_ff @(posedge i_clk) begin
        if (n_en[0]) begin
            r1_angle <= s_axis_tdata[ANGLE_W-1:0];
            r1_unit  <= r_unit;
            r1_prod  <= n1_prod;
        end
        if (n_en[1]) begin
            r2_code <= n2_code;
        end
        if (n_en[2]) begin
            r3_x   <= n3_x;
            r3_neg <= r2_code[14];
            r3_y   <= n3_p[31:13];
        end
        if (n_en[3]) begin
            r4_x   <= r3_x;
            r4_neg <= r3_neg;
            r4_y   <= n4_y[31:13];
        end
        if (n_en[4]) begin
            r5_x   <= r4_x;
            r5_neg <= r4_neg;
            r5_y   <= n5_p[31:13];
        end
        if (n_en[5]) begin
            r6_x   <= r5_x;
            r6_neg <= r5_neg;
            r6_y   <= n6_y[31:13];
        end
        if (n_en[6]) begin
            r7_sine <= r6_neg ? SINE_W'(14'd0 - n7_mag) : n7_mag;
        end
    end

endmodule
